// ----- src/tcw_pkg.sv -----
// Package with the shared constants, types and state codes of the text console writer.
package tcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int COPY_COUNT = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CELL_W     = 16;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);

    typedef struct packed {
        logic             opcode;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } tcw_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } tcw_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } tcw_state_t;

endpackage

// ----- src/text_console_writer.sv -----
// Text console writer: an 80x25 character-cell screen in RAM with a write cursor.
// Put: accept, ST_DONE, then the registered result; an in-range read passes ST_READ first.
// A scrolling put walks the screen RAM through its one read and one write port, copying up
// one cell per cycle, then filling; no new item is taken until the result is registered.
// After reset a clearing pass writes every cell while in_stall stays high; color writes
// are taken at all times and the cursor resets to row 0, col 0.
module text_console_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tcw_pkg::tcw_in_t in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output tcw_pkg::tcw_out_t out_item,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data
);

    tcw_pkg::tcw_state_t state_reg, state_next;

    logic [tcw_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [tcw_pkg::COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [7:0]                 text_color_reg, text_color_next;
    logic [tcw_pkg::CELL_W-1:0] res_cell_reg, res_cell_next;
    logic                       res_scrolled_reg, res_scrolled_next;
    logic                       out_valid_reg, out_valid_next;
    tcw_pkg::tcw_out_t          out_item_reg, out_item_next;

    logic                       accept;
    logic                       out_free;
    logic                       read_in_range;
    logic [tcw_pkg::ADDR_W-1:0] read_addr;
    logic [tcw_pkg::ADDR_W-1:0] cursor_addr;
    logic [tcw_pkg::COL_W:0]    col_step;
    logic [tcw_pkg::ROW_W:0]    row_step;
    logic                       put_scroll;
    logic [tcw_pkg::ROW_W-1:0]  put_row;

    logic                       ram_we;
    logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [tcw_pkg::ADDR_W-1:0] ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_stall  = (state_reg != tcw_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Address decode and cursor arithmetic for the item at the input.
    always_comb
    begin
        read_in_range = (int'(in_item.read_row) < tcw_pkg::SCREEN_ROWS) &&
                        (int'(in_item.read_col) < tcw_pkg::SCREEN_COLUMNS);
        read_addr   = tcw_pkg::ADDR_W'(int'(in_item.read_row) * tcw_pkg::SCREEN_COLUMNS +
                                       int'(in_item.read_col));
        cursor_addr = tcw_pkg::ADDR_W'(int'(cursor_row_reg) * tcw_pkg::SCREEN_COLUMNS +
                                       int'(cursor_col_reg));

        if (in_item.char_code == tcw_pkg::NEWLINE_CHAR)
        begin
            col_step = '0;
            row_step = (tcw_pkg::ROW_W+1)'(cursor_row_reg) + (tcw_pkg::ROW_W+1)'(1);
        end
        else
        begin
            col_step = (tcw_pkg::COL_W+1)'(cursor_col_reg) + (tcw_pkg::COL_W+1)'(1);
            row_step = (tcw_pkg::ROW_W+1)'(cursor_row_reg);
        end
        if (col_step == (tcw_pkg::COL_W+1)'(tcw_pkg::SCREEN_COLUMNS))
        begin
            col_step = '0;
            row_step = row_step + (tcw_pkg::ROW_W+1)'(1);
        end
        put_scroll = (row_step == (tcw_pkg::ROW_W+1)'(tcw_pkg::SCREEN_ROWS));
        put_row    = put_scroll ? tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)
                                : row_step[tcw_pkg::ROW_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                if (idx_reg == tcw_pkg::CELL_LAST)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.opcode == tcw_pkg::OP_READ)
                    begin
                        state_next = read_in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = put_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (idx_reg == tcw_pkg::COPY_END)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (idx_reg == tcw_pkg::CELL_LAST)
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_CLEAR;
            end
        endcase
    end

    // RAM port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {text_color_reg, tcw_pkg::BLANK_CHAR};
        ram_re    = 1'b0;
        ram_raddr = read_addr;
        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CHAR};
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.opcode == tcw_pkg::OP_READ)
                    begin
                        ram_re = read_in_range;
                    end
                    else if (in_item.char_code != tcw_pkg::NEWLINE_CHAR)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cursor_addr;
                        ram_wdata = {text_color_reg, in_item.char_code};
                    end
                end
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Read one row ahead and write the cell fetched in the previous cycle.
                if (idx_reg != tcw_pkg::COPY_END)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = tcw_pkg::ADDR_W'((tcw_pkg::ADDR_W+1)'(idx_reg) +
                                                (tcw_pkg::ADDR_W+1)'(tcw_pkg::SCREEN_COLUMNS));
                end
                if (idx_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - tcw_pkg::ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        idx_next          = idx_reg;
        cursor_row_next   = cursor_row_reg;
        cursor_col_next   = cursor_col_reg;
        text_color_next   = cfg_wr_en ? cfg_wr_data : text_color_reg;
        res_cell_next     = res_cell_reg;
        res_scrolled_next = res_scrolled_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_item_next     = out_item_reg;
        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                idx_next = (idx_reg == tcw_pkg::CELL_LAST) ? '0 : idx_reg + tcw_pkg::ADDR_W'(1);
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_cell_next     = '0;
                    res_scrolled_next = 1'b0;
                    idx_next          = '0;
                    if (in_item.opcode == tcw_pkg::OP_PUT)
                    begin
                        cursor_row_next   = put_row;
                        cursor_col_next   = col_step[tcw_pkg::COL_W-1:0];
                        res_scrolled_next = put_scroll;
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                res_cell_next = ram_rdata;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (idx_reg != tcw_pkg::COPY_END)
                begin
                    idx_next = idx_reg + tcw_pkg::ADDR_W'(1);
                end
            end
            tcw_pkg::ST_FILL:
            begin
                idx_next = idx_reg + tcw_pkg::ADDR_W'(1);
            end
            tcw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{cell_value: res_cell_reg,
                                       cursor_row: cursor_row_reg,
                                       cursor_col: cursor_col_reg,
                                       scrolled:   res_scrolled_reg};
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcw_pkg::ST_CLEAR;
            idx_reg        <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            text_color_reg <= tcw_pkg::RESET_COLOR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            text_color_reg <= text_color_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_cell_reg     <= res_cell_next;
        res_scrolled_reg <= res_scrolled_next;
        out_item_reg     <= out_item_next;
    end

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cursor_row_reg) < tcw_pkg::SCREEN_ROWS) &&
        (int'(cursor_col_reg) < tcw_pkg::SCREEN_COLUMNS))
        else $error("cursor left the screen");

    a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.scrolled |->
        out_item_reg.cursor_row == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1))
        else $error("scroll reported with cursor off the last row");

    a_scroll_ends_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcw_pkg::ST_SCROLL && idx_reg == tcw_pkg::COPY_END |=>
        state_reg == tcw_pkg::ST_FILL && idx_reg == tcw_pkg::COPY_END)
        else $error("fill did not start at the bottom row");

    a_ram_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && state_reg == tcw_pkg::ST_IDLE |-> accept &&
        in_item.opcode == tcw_pkg::OP_PUT)
        else $error("screen written while idle without a put");
`endif

endmodule

// ----- src/tcw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
